// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the Base64 stream codec.
// Self-contained; a file takes it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked at the same clock edge as the antecedent.
`define B64_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked at the next clock edge after the antecedent.
`define B64_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/b64_pkg.sv =====
// Types, constants and alphabet functions of the Base64 stream codec.
// No dependencies; used by the core and the top level.
package b64_pkg;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;   // '='
    localparam int         GROUP_BYTES = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       bad_char;
    } t_out_item;

    typedef struct packed {
        logic [23:0] group_bits;
        logic [1:0]  group_count;
        logic        bad_seen;
    } t_group_state;

    // Results caused by one transaction; chars[0] leaves first.
    typedef struct packed {
        logic [GROUP_BYTES-1:0][7:0] chars;
        logic [2:0]                  count;
        logic                        last;
        logic                        bad;
    } t_group_result;

    // 6-bit value to alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        begin
            w = {2'b00, v};
            if (v < 6'd26) begin
                enc_char = w + 8'd65;
            end else if (v < 6'd52) begin
                enc_char = w + 8'd71;
            end else if (v < 6'd62) begin
                enc_char = w - 8'd4;
            end else if (v == 6'd62) begin
                enc_char = 8'h2B;
            end else begin
                enc_char = 8'h2F;
            end
        end
    endfunction

    // Character to {invalid, 6-bit value}; invalid characters give value zero.
    function automatic logic [6:0] dec_value(input logic [7:0] c);
        begin
            if (c >= 8'h41 && c <= 8'h5A) begin
                dec_value = {1'b0, 6'(c - 8'h41)};
            end else if (c >= 8'h61 && c <= 8'h7A) begin
                dec_value = {1'b0, 6'(c - 8'h47)};
            end else if (c >= 8'h30 && c <= 8'h39) begin
                dec_value = {1'b0, 6'(c + 8'h04)};
            end else if (c == 8'h2B) begin
                dec_value = {1'b0, 6'd62};
            end else if (c == 8'h2F) begin
                dec_value = {1'b0, 6'd63};
            end else begin
                dec_value = {1'b1, 6'd0};
            end
        end
    endfunction

endpackage

// ===== rtl/b64_chan_if.sv =====
// Valid/ready channel carrying one payload per transaction.
// Payload type is a parameter; the codec uses the types of b64_pkg.
interface b64_chan_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/b64_core.sv =====
// Combinational group logic of the Base64 codec: next group state and results.
// Depends on b64_pkg for the state and result types and the alphabet functions.
module b64_core
    import b64_pkg::*;
(
    input  logic          i_dir,
    input  t_group_state  i_state,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output t_group_state  o_next,
    output t_group_result o_res
);

    // Leftover values at the end of a decode message: two give one byte,
    // three give two; a lone value is dropped.
    function automatic t_group_result dec_flush(input logic [23:0] gb,
                                                input logic [1:0] cnt,
                                                input logic bad);
        t_group_result r;
        logic [23:0]   g;
        begin
            r = '0;
            g = (cnt == 2'd2) ? {gb[11:0], 12'h000} : {gb[17:0], 6'h00};
            if (cnt >= 2'd2) begin
                r.chars[0] = g[23:16];
                r.chars[1] = g[15:8];
                r.count    = (cnt == 2'd2) ? 3'd1 : 3'd2;
                r.last     = 1'b1;
                r.bad      = bad;
            end
            dec_flush = r;
        end
    endfunction

    logic [23:0] gb_enc;
    logic [23:0] gb_dec;
    logic [23:0] g_part;
    logic [2:0]  cnt_inc;
    logic [6:0]  dv;
    logic        bad_new;

    always_comb begin
        o_next  = i_state;
        o_res   = '0;
        gb_enc  = {i_state.group_bits[15:0], i_byte};
        dv      = dec_value(i_byte);
        gb_dec  = {i_state.group_bits[17:0], dv[5:0]};
        bad_new = i_state.bad_seen | dv[6];
        cnt_inc = {1'b0, i_state.group_count} + 3'd1;
        g_part  = (cnt_inc == 3'd1) ? {gb_enc[7:0], 16'h0000} : {gb_enc[15:0], 8'h00};

        if (!i_dir) begin
            if (cnt_inc == 3'd3) begin
                o_res.chars[0] = enc_char(gb_enc[23:18]);
                o_res.chars[1] = enc_char(gb_enc[17:12]);
                o_res.chars[2] = enc_char(gb_enc[11:6]);
                o_res.chars[3] = enc_char(gb_enc[5:0]);
                o_res.count    = 3'd4;
                o_res.last     = i_last;
                o_next         = '0;
            end else if (i_last) begin
                o_res.chars[0] = enc_char(g_part[23:18]);
                o_res.chars[1] = enc_char(g_part[17:12]);
                o_res.chars[2] = (cnt_inc == 3'd2) ? enc_char(g_part[11:6]) : PAD_CHAR;
                o_res.chars[3] = PAD_CHAR;
                o_res.count    = 3'd4;
                o_res.last     = 1'b1;
                o_next         = '0;
            end else begin
                o_next.group_bits  = gb_enc;
                o_next.group_count = cnt_inc[1:0];
            end
        end else if (i_byte == PAD_CHAR) begin
            // skip padding; on the last character flush what is held
            if (i_last) begin
                o_res  = dec_flush(i_state.group_bits, i_state.group_count,
                                   i_state.bad_seen);
                o_next = '0;
            end
        end else if (cnt_inc == 3'd4) begin
            o_res.chars[0] = gb_dec[23:16];
            o_res.chars[1] = gb_dec[15:8];
            o_res.chars[2] = gb_dec[7:0];
            o_res.count    = 3'd3;
            o_res.last     = i_last;
            o_res.bad      = bad_new;
            o_next         = '0;
        end else if (i_last) begin
            o_res  = dec_flush(gb_dec, cnt_inc[1:0], bad_new);
            o_next = '0;
        end else begin
            o_next.group_bits  = gb_dec;
            o_next.group_count = cnt_inc[1:0];
            o_next.bad_seen    = bad_new;
        end
    end

endmodule

// ===== rtl/base64_stream_codec.sv =====
// Base64 stream codec top level: group state, result buffer and handshakes.
// Depends on b64_pkg, b64_chan_if and b64_core.
// Latency: results load at the accepting edge; the first is offered next cycle.
// Throughput: one transaction per cycle when it causes no result; a group of one to
//   four results drains one per ready cycle; the next is taken as its last leaves.
// Reset (i_rst_n low, synchronous): direction encodes, group and buffer clear.
module base64_stream_codec
    import b64_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    b64_chan_if.sink   i_cfg,
    b64_chan_if.sink   i_in,
    b64_chan_if.source o_out
);

    // Direction register and the partial group gathered so far.
    logic          r_dir;
    t_group_state  r_state;
    t_group_state  n_state;
    t_group_result core_res;

    // Result buffer: up to four items, shifted down as each one is taken.
    logic [GROUP_BYTES-1:0][7:0] r_buf;
    logic [2:0]                  r_cnt;
    logic                        r_last;
    logic                        r_bad;

    logic in_fire;
    logic out_fire;
    logic cfg_fire;
    logic buf_free;

    b64_core u_core (
        .i_dir   (r_dir),
        .i_state (r_state),
        .i_byte  (i_in.data.in_byte),
        .i_last  (i_in.data.in_last),
        .o_next  (n_state),
        .o_res   (core_res)
    );

    // The buffer can take a new group when empty or when its final item
    // leaves in this cycle; a transaction that causes no result never
    // touches it and is taken regardless.
    assign buf_free    = (r_cnt == 3'd0) || (r_cnt == 3'd1 && o_out.ready);
    assign i_in.ready  = buf_free || (core_res.count == 3'd0);
    assign i_cfg.ready = 1'b1;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;

    assign o_out.valid         = (r_cnt != 3'd0);
    assign o_out.data.out_byte = r_buf[0];
    assign o_out.data.out_last = r_last && (r_cnt == 3'd1);
    assign o_out.data.bad_char = r_bad;

    // Control state: direction, group and buffer fill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= 1'b0;
            r_state <= '0;
            r_cnt   <= 3'd0;
        end else begin
            if (cfg_fire) begin
                // a direction write starts a fresh group
                r_dir   <= i_cfg.data;
                r_state <= '0;
            end else if (in_fire) begin
                r_state <= n_state;
            end

            if (in_fire && core_res.count != 3'd0) begin
                r_cnt <= core_res.count;
            end else if (out_fire) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    // Payload of the buffer: load a fresh group, or advance by one item.
    always_ff @(posedge i_clk) begin
        if (in_fire && core_res.count != 3'd0) begin
            r_buf  <= core_res.chars;
            r_last <= core_res.last;
            r_bad  <= core_res.bad;
        end else if (out_fire) begin
            r_buf <= {8'h00, r_buf[GROUP_BYTES-1:1]};
        end
    end

endmodule

// ===== rtl/b64_checker.sv =====
// Port-level checks of the Base64 stream codec, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module b64_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last,
    input logic       i_out_bad
);

    // A stalled result holds its payload.
    `B64_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_last) && $stable(i_out_bad), "stalled result changed")

    // With nothing waiting at the output the input is never held off.
    `B64_ASSERT_SAME(a_in_ready_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input stalled with empty output")

    // Results appear only after an accepted input transaction.
    `B64_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !i_out_valid && !(i_in_valid && i_in_ready), !i_out_valid, "result without input")

endmodule

bind base64_stream_codec b64_checker u_b64_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.data.out_byte),
    .i_out_last  (o_out.data.out_last),
    .i_out_bad   (o_out.data.bad_char)
);
